[hw/rtl/lfd_pkg.sv]
// lfd_pkg: shared types, codes and constants of the lfast frame deframer
// no dependencies; used by every module in hw/rtl
package lfd_pkg;

	localparam logic [15:0] SYNC_RESET   = 16'hA84B;
	localparam logic [4:0]  SYNC_BITS    = 5'd16;
	localparam logic [4:0]  BYTE_BITS    = 5'd8;
	localparam logic [3:0]  DATA_CH_LOW  = 4'd4;
	localparam logic [3:0]  DATA_CH_HIGH = 4'd11;

	typedef enum logic {
		OP_BIT     = 1'b0,
		OP_TIMEOUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_SYNC    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SLEEP   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_SYNC_OK  = 3'd0,
		KIND_SYNC_ERR = 3'd1,
		KIND_HEADER   = 3'd2,
		KIND_PAYLOAD  = 3'd3,
		KIND_SLEEP    = 3'd4
	} kind_t;

	typedef struct packed {
		op_t  op;
		logic bit_value;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [2:0]  size_code;
		logic [3:0]  channel_type;
		logic        clear_to_send;
		logic [5:0]  byte_index;
		logic        data_channel;
		logic        last_byte;
		logic        sleep_request;
	} result_t;

	// front to back handshake
	typedef struct packed {
		logic  valid;
		item_t item;
	} front_out_t;

	function automatic logic [6:0] size_bytes(input logic [2:0] code);
		logic [6:0] n;
		case (code)
			3'd0:    n = 7'd1;
			3'd1:    n = 7'd4;
			3'd2:    n = 7'd8;
			3'd3:    n = 7'd12;
			3'd4:    n = 7'd16;
			3'd5:    n = 7'd32;
			3'd6:    n = 7'd64;
			3'd7:    n = 7'd36;
			default: n = 7'd1;
		endcase
		return n;
	endfunction

endpackage

[hw/rtl/lfd_front.sv]
// lfd_front: input side, accepts and classifies line events into a two-entry queue
// depends on lfd_pkg
module lfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic                bit_value,
	output lfd_pkg::front_out_t front_out,
	input  logic                take
);

	lfd_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_take;
	lfd_pkg::item_t new_item;

	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_take = take && (count_q != 2'd0);

	always_comb begin
		new_item.op        = operation ? lfd_pkg::OP_TIMEOUT : lfd_pkg::OP_BIT;
		// level is meaningless on a timeout
		new_item.bit_value = operation ? 1'b0 : bit_value;
	end

	assign front_out.valid = (count_q != 2'd0);
	assign front_out.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/lfd_engine.sv]
// lfd_engine: back side frame state machine, one line event per cycle while the result queue is not full
// depends on lfd_pkg
module lfd_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  lfd_pkg::front_out_t front_out,
	input  logic                res_full,
	input  logic [15:0]         sync_pattern_q,
	output logic                take,
	output logic                res_wr,
	output lfd_pkg::result_t    res_data
);

	lfd_pkg::phase_t phase_q, phase_d;
	logic [4:0]      bit_cnt_q, bit_cnt_d;
	logic [15:0]     window_q, window_d;
	logic [6:0]      pay_len_q, pay_len_d;
	logic [3:0]      chan_q, chan_d;
	logic [6:0]      bytes_q, bytes_d;
	logic [15:0]     window_n;
	logic [4:0]      cnt_n;
	logic [7:0]      hdr;
	logic            last;
	logic            emit;

	assign take     = front_out.valid && !res_full;
	assign res_wr   = take && emit;
	assign window_n = {window_q[14:0], front_out.item.bit_value};
	assign cnt_n    = bit_cnt_q + 5'd1;
	assign hdr      = window_n[7:0];
	assign last     = ({1'b0, bytes_q} + 8'd1) >= {1'b0, pay_len_q};

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		window_d  = window_q;
		pay_len_d = pay_len_q;
		chan_d    = chan_q;
		bytes_d   = bytes_q;
		emit      = 1'b0;
		res_data  = '0;
		res_data.kind = lfd_pkg::KIND_SYNC_OK;

		if (front_out.item.op == lfd_pkg::OP_TIMEOUT) begin
			if (phase_q == lfd_pkg::PH_SLEEP) begin
				emit          = 1'b1;
				res_data.kind = lfd_pkg::KIND_SLEEP;
			end
			phase_d   = lfd_pkg::PH_SYNC;
			bit_cnt_d = '0;
			window_d  = '0;
			pay_len_d = '0;
			chan_d    = '0;
			bytes_d   = '0;
		end else begin
			window_d  = window_n;
			bit_cnt_d = cnt_n;
			case (phase_q)
				lfd_pkg::PH_SYNC: begin
					if (cnt_n == lfd_pkg::SYNC_BITS) begin
						emit      = 1'b1;
						bit_cnt_d = '0;
						window_d  = '0;
						if (window_n == sync_pattern_q) begin
							res_data.kind = lfd_pkg::KIND_SYNC_OK;
							phase_d       = lfd_pkg::PH_HEADER;
						end else begin
							res_data.kind  = lfd_pkg::KIND_SYNC_ERR;
							res_data.value = window_n;
						end
					end
				end
				lfd_pkg::PH_HEADER: begin
					if (cnt_n == lfd_pkg::BYTE_BITS) begin
						emit                   = 1'b1;
						res_data.kind          = lfd_pkg::KIND_HEADER;
						res_data.value         = {8'd0, hdr};
						res_data.size_code     = hdr[7:5];
						res_data.channel_type  = hdr[4:1];
						res_data.clear_to_send = hdr[0];
						chan_d    = hdr[4:1];
						pay_len_d = lfd_pkg::size_bytes(hdr[7:5]);
						bytes_d   = '0;
						bit_cnt_d = '0;
						window_d  = '0;
						phase_d   = lfd_pkg::PH_PAYLOAD;
					end
				end
				lfd_pkg::PH_PAYLOAD: begin
					if (cnt_n == lfd_pkg::BYTE_BITS) begin
						emit                  = 1'b1;
						res_data.kind         = lfd_pkg::KIND_PAYLOAD;
						res_data.value        = {8'd0, hdr};
						res_data.channel_type = chan_q;
						res_data.byte_index   = bytes_q[5:0];
						res_data.data_channel = chan_q inside
							{[lfd_pkg::DATA_CH_LOW:lfd_pkg::DATA_CH_HIGH]};
						res_data.last_byte    = last;
						bytes_d   = bytes_q + 7'd1;
						bit_cnt_d = '0;
						window_d  = '0;
						if (last) begin
							phase_d = lfd_pkg::PH_SLEEP;
						end
					end
				end
				lfd_pkg::PH_SLEEP: begin
					emit                   = 1'b1;
					res_data.kind          = lfd_pkg::KIND_SLEEP;
					res_data.sleep_request = front_out.item.bit_value;
					phase_d   = lfd_pkg::PH_SYNC;
					bit_cnt_d = '0;
					window_d  = '0;
					pay_len_d = '0;
					chan_d    = '0;
					bytes_d   = '0;
				end
				default: begin
					phase_d = lfd_pkg::PH_SYNC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lfd_pkg::PH_SYNC;
			bit_cnt_q <= '0;
			window_q  <= '0;
			pay_len_q <= '0;
			chan_q    <= '0;
			bytes_q   <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			window_q  <= window_d;
			pay_len_q <= pay_len_d;
			chan_q    <= chan_d;
			bytes_q   <= bytes_d;
		end
	end

endmodule

[hw/rtl/lfd_result_queue.sv]
// lfd_result_queue: two-entry queue of decoded results toward the output port
// depends on lfd_pkg
module lfd_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  lfd_pkg::result_t wr_data,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output lfd_pkg::result_t rd_data
);

	lfd_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_wr    = wr && !res_full;
	assign do_rd    = pop && !empty;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/lfast_frame_deframer_unit.sv]
// lfast_frame_deframer_unit: top level of the lfast frame deframer
// depends on lfd_pkg, lfd_front, lfd_engine, lfd_result_queue
//
// usage:
//   input channel is a queue write side: present operation/bit_value with push;
//   a transaction completes on a clock edge with push high and full low.
//   operation 0 carries one recovered line bit (msb first), 1 a line idle timeout.
//   results are read like a queue: while empty is low the oldest result is on
//   kind/value/size_code/... and a transaction completes with pop high.
//   each line event yields zero or one result: sync ok or sync error after 16
//   bits, header after 8, one per payload byte, then the sleep bit.
//   cfg_valid/cfg_ready/cfg_data write the sync pattern; cfg_ready is always high.
// timing:
//   one line event per cycle sustained while the result queue is not full; the frame
//   engine handles one event a cycle unless stalled. A result passes from the input
//   queue through the engine into the result queue, whose head drives the outputs.
//   if pop stays low the two-entry result queue fills, the engine stops, then the
//   two-entry input queue fills and full rises; nothing is dropped.
// reset:
//   arst_n empties both queues, returns the engine to sync search with all
//   counters clear, and loads the sync pattern with 0xA84B.
module lfast_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic        bit_value,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [15:0] value,
	output logic [2:0]  size_code,
	output logic [3:0]  channel_type,
	output logic        clear_to_send,
	output logic [5:0]  byte_index,
	output logic        data_channel,
	output logic        last_byte,
	output logic        sleep_request,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	lfd_pkg::front_out_t front_out;
	lfd_pkg::result_t    res_wr_data;
	lfd_pkg::result_t    res_rd_data;
	logic                take;
	logic                res_wr;
	logic                res_full;
	logic [15:0]         sync_pattern_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= lfd_pkg::SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_pattern_q <= cfg_data;
		end
	end

	lfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.bit_value (bit_value),
		.front_out (front_out),
		.take      (take)
	);

	lfd_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.front_out      (front_out),
		.res_full       (res_full),
		.sync_pattern_q (sync_pattern_q),
		.take           (take),
		.res_wr         (res_wr),
		.res_data       (res_wr_data)
	);

	lfd_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_wr),
		.wr_data  (res_wr_data),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.rd_data  (res_rd_data)
	);

	assign kind          = res_rd_data.kind;
	assign value         = res_rd_data.value;
	assign size_code     = res_rd_data.size_code;
	assign channel_type  = res_rd_data.channel_type;
	assign clear_to_send = res_rd_data.clear_to_send;
	assign byte_index    = res_rd_data.byte_index;
	assign data_channel  = res_rd_data.data_channel;
	assign last_byte     = res_rd_data.last_byte;
	assign sleep_request = res_rd_data.sleep_request;

endmodule
